>>> rtl/core/pwic_pkg.sv
// Shared types and constants for the PID controller with integral clamp.
package pwic_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned GAIN_W  = 31;
  localparam int unsigned BOUND_W = 47;
  localparam int unsigned CFG_W   = 47;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned OP_W    = 2 * MUL_W;
  localparam int unsigned PROD_W  = MUL_W + GAIN_W;
  localparam int unsigned FULL_W  = PROD_W + MUL_W;
  localparam int unsigned CAP_EXP = 60;
  localparam int unsigned TERM_W  = CAP_EXP + 1;
  localparam int unsigned SUM_W   = 64;

  localparam logic signed [SUM_W-1:0] ACC_MAX = (SUM_W'(1) << (ACC_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_LO    = 7'b0000100,
    ST_HI    = 7'b0001000,
    ST_FIN   = 7'b0010000,
    ST_APPLY = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  typedef enum logic [3:0] {
    TM_PROP  = 4'b0001,
    TM_DERIV = 4'b0010,
    TM_STEP  = 4'b0100,
    TM_INT   = 4'b1000
  } term_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_KP    = 3'd1,
    CFG_KI    = 3'd2,
    CFG_KD    = 3'd3,
    CFG_TS    = 3'd4,
    CFG_LIMIT = 3'd5,
    CFG_BOUND = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              en;
    logic [MUL_W-1:0]  digit;
    logic [GAIN_W-1:0] gain;
  } mul_req_t;

endpackage

>>> rtl/core/pwic_mul.sv
// Shared registered multiplier: one operand digit times one gain per cycle while the request is enabled.
module pwic_mul (
  input  logic                           clk_i,
  input  pwic_pkg::mul_req_t             req_i,
  output logic [pwic_pkg::PROD_W-1:0]    prod_o
);

  logic [pwic_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= pwic_pkg::PROD_W'(req_i.digit) * pwic_pkg::PROD_W'(req_i.gain);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/pid_with_integral_clamp.sv
// PID / PD controller with integral clamp; one shared multiplier under a sequencer.
// The next item is taken only after the last one is through the sequencer; each gain
// term takes five sequencer steps, two of them passes through the 32x31 multiplier.
// A finished result waits in the output register while the next item is taken.
// Reset (async, low) clears integral, previous error and config to defaults.
module pid_with_integral_clamp #(
  parameter int unsigned DATA_WIDTH = pwic_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = pwic_pkg::FRAC_BITS_DEF,
  localparam int unsigned InDataW   = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwic_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [pwic_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [InDataW-1:0]            s_axis_tdata,   // [DATA_WIDTH-1:0] error_sample
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pwic_pkg::OUT_W-1:0]    m_axis_tdata,   // [31:0] drive_value
  output logic                          m_axis_tuser    // [0] saturated
);

  localparam int unsigned OpW   = pwic_pkg::OP_W;
  localparam int unsigned MulW  = pwic_pkg::MUL_W;
  localparam int unsigned SumW  = pwic_pkg::SUM_W;
  localparam int unsigned AccW  = pwic_pkg::ACC_W;
  localparam int unsigned TermW = pwic_pkg::TERM_W;
  localparam int unsigned FullW = pwic_pkg::FULL_W;
  localparam int unsigned GainW = pwic_pkg::GAIN_W;
  localparam logic [FullW-1:0] CapFull = FullW'(1) << pwic_pkg::CAP_EXP;

  // configuration
  logic                         mode_pd_q;
  logic [GainW-1:0]             kp_q, ki_q, kd_q, ts_q, limit_q;
  logic [pwic_pkg::BOUND_W-1:0] bound_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_pd_q <= 1'b0;
      kp_q      <= '0;
      ki_q      <= '0;
      kd_q      <= '0;
      ts_q      <= '0;
      limit_q   <= '1;
      bound_q   <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pwic_pkg::cfg_idx_e'(cfg_index_i))
        pwic_pkg::CFG_MODE:  mode_pd_q <= cfg_data_i[0];
        pwic_pkg::CFG_KP:    kp_q      <= cfg_data_i[GainW-1:0];
        pwic_pkg::CFG_KI:    ki_q      <= cfg_data_i[GainW-1:0];
        pwic_pkg::CFG_KD:    kd_q      <= cfg_data_i[GainW-1:0];
        pwic_pkg::CFG_TS:    ts_q      <= cfg_data_i[GainW-1:0];
        pwic_pkg::CFG_LIMIT: limit_q   <= cfg_data_i[GainW-1:0];
        pwic_pkg::CFG_BOUND: bound_q   <= cfg_data_i[pwic_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  pwic_pkg::state_e state_q, state_d;
  pwic_pkg::term_e  term_q;

  logic signed [DATA_WIDTH-1:0] e_q, prev_q;
  logic signed [AccW-1:0]       integral_q, int_new_q;
  logic signed [SumW-1:0]       sum_q;
  logic [OpW-1:0]               mag_q;
  logic                         neg_q;
  logic [pwic_pkg::PROD_W-1:0]  acc_lo_q;
  logic [TermW-1:0]             tmag_q;
  logic                         m_valid_q, m_sat_q;
  logic [pwic_pkg::OUT_W-1:0]   m_drive_q;

  logic [DATA_WIDTH:0]          diff;
  logic [OpW-1:0]               op_val, op_mag;
  logic [GainW-1:0]             gain_sel;
  pwic_pkg::mul_req_t           mul_req;
  logic [pwic_pkg::PROD_W-1:0]  prod;
  logic [FullW-1:0]             full, shifted;
  logic signed [SumW-1:0]       term_s, isum, lim_s, bnd_s, int_ext;
  logic                         out_free;

  assign diff = {e_q[DATA_WIDTH-1], e_q} - {prev_q[DATA_WIDTH-1], prev_q};

  always_comb begin
    unique case (term_q)
      pwic_pkg::TM_PROP, pwic_pkg::TM_STEP:
        op_val = {{(OpW-DATA_WIDTH){e_q[DATA_WIDTH-1]}}, e_q};
      pwic_pkg::TM_DERIV:
        op_val = {{(OpW-DATA_WIDTH-1){diff[DATA_WIDTH]}}, diff};
      pwic_pkg::TM_INT:
        op_val = {{(OpW-AccW){int_new_q[AccW-1]}}, int_new_q};
      default: op_val = '0;
    endcase
    unique case (term_q)
      pwic_pkg::TM_PROP:  gain_sel = kp_q;
      pwic_pkg::TM_DERIV: gain_sel = kd_q;
      pwic_pkg::TM_STEP:  gain_sel = ts_q;
      pwic_pkg::TM_INT:   gain_sel = ki_q;
      default:            gain_sel = '0;
    endcase
  end

  assign op_mag = op_val[OpW-1] ? (~op_val + OpW'(1)) : op_val;

  assign mul_req.en    = (state_q == pwic_pkg::ST_LO) || (state_q == pwic_pkg::ST_HI);
  assign mul_req.digit = (state_q == pwic_pkg::ST_LO) ? mag_q[MulW-1:0] : mag_q[OpW-1:MulW];
  assign mul_req.gain  = gain_sel;

  pwic_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign full    = {prod, {MulW{1'b0}}} + FullW'(acc_lo_q);
  assign shifted = full >> FRAC_BITS;

  assign term_s  = neg_q ? -$signed(SumW'(tmag_q)) : $signed(SumW'(tmag_q));
  assign isum    = $signed({{(SumW-AccW){integral_q[AccW-1]}}, integral_q}) + term_s;
  assign lim_s   = $signed(SumW'(limit_q));
  assign bnd_s   = $signed(SumW'(bound_q));
  assign int_ext = $signed({{(SumW-AccW){int_new_q[AccW-1]}}, int_new_q});
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwic_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = pwic_pkg::ST_LOAD;
      pwic_pkg::ST_LOAD:  state_d = pwic_pkg::ST_LO;
      pwic_pkg::ST_LO:    state_d = pwic_pkg::ST_HI;
      pwic_pkg::ST_HI:    state_d = pwic_pkg::ST_FIN;
      pwic_pkg::ST_FIN:   state_d = pwic_pkg::ST_APPLY;
      pwic_pkg::ST_APPLY: begin
        if ((term_q == pwic_pkg::TM_INT) ||
            ((term_q == pwic_pkg::TM_DERIV) && mode_pd_q)) begin
          state_d = pwic_pkg::ST_OUT;
        end else begin
          state_d = pwic_pkg::ST_LOAD;
        end
      end
      pwic_pkg::ST_OUT:   if (out_free) state_d = pwic_pkg::ST_IDLE;
      default:            state_d = pwic_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == pwic_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pwic_pkg::ST_IDLE;
      term_q     <= pwic_pkg::TM_PROP;
      integral_q <= '0;
      prev_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tready && (state_q != pwic_pkg::ST_OUT)) m_valid_q <= 1'b0;
      unique case (state_q)
        pwic_pkg::ST_IDLE: term_q <= pwic_pkg::TM_PROP;
        pwic_pkg::ST_APPLY: begin
          unique case (term_q)
            pwic_pkg::TM_PROP:  term_q <= pwic_pkg::TM_DERIV;
            pwic_pkg::TM_DERIV: term_q <= pwic_pkg::TM_STEP;
            pwic_pkg::TM_STEP:  term_q <= pwic_pkg::TM_INT;
            default:            term_q <= pwic_pkg::TM_PROP;
          endcase
        end
        pwic_pkg::ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            prev_q    <= e_q;
            if (!mode_pd_q) begin
              if (int_ext > bnd_s)       integral_q <= bnd_s[AccW-1:0];
              else if (int_ext < -bnd_s) integral_q <= -bnd_s[AccW-1:0];
              else                       integral_q <= int_new_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      pwic_pkg::ST_IDLE: begin
        e_q   <= s_axis_tdata[DATA_WIDTH-1:0];
        sum_q <= '0;
      end
      pwic_pkg::ST_LOAD: begin
        mag_q <= op_mag;
        neg_q <= op_val[OpW-1];
      end
      pwic_pkg::ST_HI:  acc_lo_q <= prod;
      pwic_pkg::ST_FIN: tmag_q <= (shifted > CapFull) ? CapFull[TermW-1:0]
                                                      : shifted[TermW-1:0];
      pwic_pkg::ST_APPLY: begin
        if (term_q == pwic_pkg::TM_STEP) begin
          if (isum > pwic_pkg::ACC_MAX)      int_new_q <= pwic_pkg::ACC_MAX[AccW-1:0];
          else if (isum < pwic_pkg::ACC_MIN) int_new_q <= pwic_pkg::ACC_MIN[AccW-1:0];
          else                               int_new_q <= isum[AccW-1:0];
        end else begin
          sum_q <= sum_q + term_s;
        end
      end
      pwic_pkg::ST_OUT: begin
        if (out_free) begin
          if (sum_q >= lim_s) begin
            m_drive_q <= lim_s[pwic_pkg::OUT_W-1:0];
            m_sat_q   <= 1'b1;
          end else if (sum_q <= -lim_s) begin
            m_drive_q <= -lim_s[pwic_pkg::OUT_W-1:0];
            m_sat_q   <= 1'b1;
          end else begin
            m_drive_q <= sum_q[pwic_pkg::OUT_W-1:0];
            m_sat_q   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_drive_q;
  assign m_axis_tuser  = m_sat_q;

  // checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == pwic_pkg::ST_LOAD))
    else $error("accepted item did not start the sequencer");

  a_drive_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed({m_axis_tdata[pwic_pkg::OUT_W-1], m_axis_tdata}) <=
         $signed({2'b00, limit_q})) &&
      ($signed({m_axis_tdata[pwic_pkg::OUT_W-1], m_axis_tdata}) >=
         -$signed({2'b00, limit_q})))
    else $error("drive value outside limit");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      ((m_axis_tdata == pwic_pkg::OUT_W'(limit_q)) ||
       (m_axis_tdata == -pwic_pkg::OUT_W'(limit_q))))
    else $error("saturated flag without drive at limit");

endmodule

>>> dv/tb_top.sv
// Testbench for pid_with_integral_clamp: directed and random error streams checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import pwic_pkg::*;

  localparam int unsigned FracBits   = FRAC_BITS_DEF;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemTarget = 1600;
  localparam int unsigned DrainWait  = 40;
  localparam int          EOne       = 1 << FRAC_BITS_DEF;

  localparam logic [IDX_W-1:0] CfgUnused = 3'd7;
  localparam logic [CFG_W-1:0] ModePid   = '0;
  localparam logic [CFG_W-1:0] ModePd    = CFG_W'(1);
  localparam logic [CFG_W-1:0] QOne      = CFG_W'(1) << FRAC_BITS_DEF;
  localparam logic [CFG_W-1:0] GainMax   = (CFG_W'(1) << GAIN_W) - CFG_W'(1);
  localparam logic [CFG_W-1:0] BoundMax  = (CFG_W'(1) << BOUND_W) - CFG_W'(1);
  localparam logic [63:0]      TermCap   = 64'd1 << CAP_EXP;

  typedef struct packed {
    logic [OUT_W-1:0] drive;
    logic             sat;
  } drive_t;

  class drive_tracker;
    logic                pd_only  = 1'b0;
    logic [GAIN_W-1:0]   kp       = '0;
    logic [GAIN_W-1:0]   ki       = '0;
    logic [GAIN_W-1:0]   kd_rate  = '0;
    logic [GAIN_W-1:0]   ts       = '0;
    logic [GAIN_W-1:0]   limit    = '1;
    logic [BOUND_W-1:0]  bound    = '1;
    logic signed [63:0]  integ    = '0;
    logic signed [63:0]  last_err = '0;
    drive_t              pending_drives[$];
    int                  mismatches = 0;

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_MODE:  pd_only = val[0];
        CFG_KP:    kp = val[GAIN_W-1:0];
        CFG_KI:    ki = val[GAIN_W-1:0];
        CFG_KD:    kd_rate = val[GAIN_W-1:0];
        CFG_TS:    ts = val[GAIN_W-1:0];
        CFG_LIMIT: limit = val[GAIN_W-1:0];
        CFG_BOUND: bound = val[BOUND_W-1:0];
        default: ;
      endcase
    endfunction

    // magnitude product, fraction truncated, capped at 2^60, sign restored
    function logic signed [63:0] scaled(logic signed [63:0] v, logic [GAIN_W-1:0] g);
      logic [63:0]  mag;
      logic [127:0] full;
      logic [63:0]  p;
      mag  = v[63] ? -v : v;
      full = (128'(mag) * 128'(g)) >> FracBits;
      p    = (full > 128'(TermCap)) ? TermCap : full[63:0];
      return v[63] ? -signed'(p) : signed'(p);
    endfunction

    function void take_error(logic [DATA_WIDTH_DEF-1:0] raw);
      logic signed [63:0] e;
      logic signed [63:0] sum;
      logic signed [63:0] acc;
      logic signed [63:0] bnd;
      logic signed [63:0] lim;
      drive_t             want;
      e   = {{(64 - DATA_WIDTH_DEF){raw[DATA_WIDTH_DEF-1]}}, raw};
      sum = scaled(e, kp) + scaled(e - last_err, kd_rate);
      if (!pd_only) begin
        acc = integ + scaled(e, ts);
        if (acc > ACC_MAX) acc = ACC_MAX;
        else if (acc < ACC_MIN) acc = ACC_MIN;
        sum += scaled(acc, ki);
        bnd = {{(64 - BOUND_W){1'b0}}, bound};
        if (acc > bnd) acc = bnd;
        else if (acc < -bnd) acc = -bnd;
        integ = acc;
      end
      lim = {{(64 - GAIN_W){1'b0}}, limit};
      if (sum >= lim) begin
        want.drive = lim[OUT_W-1:0];
        want.sat   = 1'b1;
      end else if (sum <= -lim) begin
        sum        = -lim;
        want.drive = sum[OUT_W-1:0];
        want.sat   = 1'b1;
      end else begin
        want.drive = sum[OUT_W-1:0];
        want.sat   = 1'b0;
      end
      last_err = e;
      pending_drives.push_back(want);
    endfunction

    function void match_drive(logic [OUT_W-1:0] drive, logic sat);
      drive_t want;
      if (pending_drives.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, drive_value %h saturated %b", $time, drive, sat);
        return;
      end
      want = pending_drives.pop_front();
      if (drive !== want.drive) begin
        mismatches++;
        $display("%0t: drive_value expected %h actual %h", $time, want.drive, drive);
      end
      if (sat !== want.sat) begin
        mismatches++;
        $display("%0t: saturated expected %b actual %b", $time, want.sat, sat);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [IDX_W-1:0]    cfg_index_i   = '0;
  logic [CFG_W-1:0]    cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata  = '0;  // [31:0] error_sample
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // [31:0] drive_value
  logic                m_axis_tuser;        // [0] saturated

  drive_tracker board = new;
  int  quiet_cycles   = 0;
  int  items_sent     = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_req       = 1'b0;

  pid_with_integral_clamp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) board.set_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && s_axis_tvalid && s_axis_tready) board.take_error(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.match_drive(m_axis_tdata, m_axis_tuser);
    if (rst_ni && ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
                   (m_axis_tvalid && m_axis_tready))) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("tb_top failed");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_error(input logic [31:0] e);
    @(negedge clk_i);
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_drives.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_W-1:0] mode, input logic [CFG_W-1:0] p,
                           input logic [CFG_W-1:0] i, input logic [CFG_W-1:0] d,
                           input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] lim,
                           input logic [CFG_W-1:0] bnd);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_KP, p);
    write_reg(CFG_KI, i);
    write_reg(CFG_KD, d);
    write_reg(CFG_TS, t);
    write_reg(CFG_LIMIT, lim);
    write_reg(CFG_BOUND, bnd);
  endtask

  // zero, all ones in the register, or fully random including bits above it
  function automatic logic [CFG_W-1:0] pick_reg(input int unsigned w);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return (CFG_W'(1) << w) - CFG_W'(1);
      default: return CFG_W'({$urandom, $urandom});
    endcase
  endfunction

  initial begin
    int          n;
    int          bias;
    int          spread;
    int          phase;
    bit          wild;
    bit          tail;
    logic [31:0] e;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: all gains zero
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    settle();

    // moderate PID, integral winds into a small clamp
    write_all(ModePid, QOne, QOne >> 1, QOne >> 2, QOne >> 1, 10 * QOne, 4 * QOne);
    send_error(0);
    send_error(EOne);
    send_error(3 * EOne);
    send_error(3 * EOne);
    send_error(3 * EOne);
    send_error(-EOne);
    send_error(32'h0000_0001);
    send_error(32'hFFFF_FFFF);
    settle();

    // every gain, the limit and the bound at their top: product cap and output saturation
    write_all(ModePid, GainMax, GainMax, GainMax, GainMax, GainMax, BoundMax);
    send_error(32'h7FFF_FFFF);
    send_error(32'h7FFF_FFFF);
    send_error(32'h8000_0000);
    send_error(32'h8000_0000);
    send_error(32'h8000_0000);
    settle();

    // zero limit, zero bound, zero sample period
    write_all(ModePid, QOne, QOne, QOne, '0, '0, '0);
    send_error(5 * EOne);
    send_error(-5 * EOne);
    settle();

    // PD only, output hitting the limit exactly
    write_all(ModePd, QOne, GainMax, '0, GainMax, 10 * QOne, '0);
    send_error(10 * EOne);
    send_error(10 * EOne - 1);
    send_error(-10 * EOne);
    settle();
    write_reg(CfgUnused, BoundMax);
    write_reg(CFG_KD, GainMax);
    send_error(EOne);
    settle();

    phase = 0;
    while (items_sent < ItemTarget) begin
      tail = (items_sent >= ItemTarget * 4 / 5);
      wild = ($urandom_range(0, 9) < 3);
      if (wild) begin
        write_all(pick_reg(1), pick_reg(GAIN_W), pick_reg(GAIN_W), pick_reg(GAIN_W),
                  pick_reg(GAIN_W), pick_reg(GAIN_W), pick_reg(BOUND_W));
      end else begin
        write_all(($urandom_range(0, 3) == 0) ? ModePd : ModePid,
                  $urandom_range(0, 8 * EOne), $urandom_range(0, 2 * EOne),
                  $urandom_range(0, 4 * EOne), $urandom_range(0, EOne),
                  $urandom_range(EOne, 30000 * EOne),
                  CFG_W'($urandom) >> $urandom_range(0, 16));
      end
      if ($urandom_range(0, 7) == 0) write_reg(CfgUnused, pick_reg(CFG_W));

      send_idle_pct  = tail ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40));
      recv_stall_pct = tail ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40));
      if (phase == 2) hold_req = 1'b1;

      bias   = int'($urandom_range(0, 200 * EOne)) - 100 * EOne;
      spread = $urandom_range(1, 50 * EOne);
      n      = $urandom_range(40, 120);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 39) == 0) bias = -bias;
        case ($urandom_range(0, 9))
          0:       e = $urandom;
          1:       e = int'($urandom_range(0, 512)) - 256;
          2:       e = wild ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                            : bias;
          default: e = wild ? $urandom : bias + int'($urandom_range(0, 2 * spread)) - spread;
        endcase
        send_error(e);
      end
      settle();
      phase++;
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DrainWait) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_drives.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
